// ===== rtl/enrq_pkg.sv =====
// shared types and constants for the event notification ring queue
// no dependencies; imported by every module of the block
package enrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // configuration port
    localparam int                  CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 2'd1;
    localparam logic [15:0]          WIN_LOW_RST  = 16'd3000;
    localparam logic [15:0]          WIN_HIGH_RST = 16'd5000;

    // host commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FETCH  = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // reply kinds and insert status codes
    localparam logic       KIND_STATUS = 1'b0;
    localparam logic       KIND_BYTE   = 1'b1;
    localparam logic [7:0] STATUS_OK   = 8'd0;
    localparam logic [7:0] STATUS_REJ  = 8'd1;

    typedef enum logic [1:0] {
        OP_INS_OK,
        OP_INS_REJ,
        OP_FETCH,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] data;
    } cmd_entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_EMIT
    } back_state_t;

endpackage

// ===== rtl/enrq_front.sv =====
// front end: takes host requests, checks insert rules, keeps ready flag and window
// depends on enrq_pkg; feeds enrq_cmdq
module enrq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [7:0]                    event_class,
    input  logic [7:0]                    event_id,
    input  logic [15:0]                   power_state,
    input  logic [7:0]                    ready_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [enrq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          q_full,
    output logic                          push,
    output enrq_pkg::cmd_entry_t          push_entry
);
    import enrq_pkg::*;

    logic [15:0] win_low_reg, win_low_next;
    logic [15:0] win_high_reg, win_high_next;
    logic        ready_reg, ready_next;
    logic        accept;
    logic        insert_ok;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !q_full;
    assign insert_ok = (power_state >= win_low_reg) && (power_state <= win_high_reg)
                       && ready_reg && (event_class != 8'd0);

    always_comb
    begin
        win_low_next    = win_low_reg;
        win_high_next   = win_high_reg;
        ready_next      = ready_reg;
        push            = 1'b0;
        push_entry.op   = OP_FETCH;
        push_entry.data = {event_class, event_id};
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIN_LOW:  win_low_next  = cfg_data;
                CFG_WIN_HIGH: win_high_next = cfg_data;
                default:      ;
            endcase
        end
        if (accept)
        begin
            case (command)
                CMD_INSERT:
                begin
                    push          = 1'b1;
                    push_entry.op = insert_ok ? OP_INS_OK : OP_INS_REJ;
                end
                CMD_FETCH:
                begin
                    push          = 1'b1;
                    push_entry.op = OP_FETCH;
                end
                CMD_SET:
                begin
                    // other values leave the flag alone
                    if (ready_value == 8'd0)
                        ready_next = 1'b0;
                    else if (ready_value == 8'd1)
                        ready_next = 1'b1;
                end
                CMD_READ:
                begin
                    push            = 1'b1;
                    push_entry.op   = OP_READ;
                    push_entry.data = {15'd0, ready_reg};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= WIN_LOW_RST;
            win_high_reg <= WIN_HIGH_RST;
            ready_reg    <= 1'b0;
        end
        else
        begin
            win_low_reg  <= win_low_next;
            win_high_reg <= win_high_next;
            ready_reg    <= ready_next;
        end
    end

endmodule

// ===== rtl/enrq_cmdq.sv =====
// short command queue between front and back end
// depends on enrq_pkg
module enrq_cmdq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  enrq_pkg::cmd_entry_t push_entry,
    output logic                 q_full,
    output logic                 q_valid,
    output enrq_pkg::cmd_entry_t q_entry,
    input  logic                 pop
);
    import enrq_pkg::*;

    cmd_entry_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]       wr_reg, wr_next;
    logic [CMDQ_PTR_W-1:0]       rd_reg, rd_next;
    logic [CMDQ_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                        do_pop;

    assign q_full  = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = slot_reg[rd_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/enrq_back.sv =====
// back end: event ring storage, pointers, interrupt line and reply sequencing
// depends on enrq_pkg; drains enrq_cmdq
module enrq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  enrq_pkg::cmd_entry_t q_entry,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 reply_kind,
    output logic [7:0]           reply_data,
    output logic                 last_byte,
    output logic                 irq_level
);
    import enrq_pkg::*;

    logic [15:0]      mem [QUEUE_DEPTH];
    logic [15:0]      rdata_reg;
    logic             mem_we;

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             irq_reg, irq_next;
    logic             empty_reg, empty_next;
    logic [7:0]       hold_a_reg, hold_a_next;
    logic [7:0]       hold_b_reg, hold_b_next;
    logic [1:0]       left_reg, left_next;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic             oirq_reg, oirq_next;

    logic             can_load;
    logic [15:0]      value;

    assign out_valid  = out_valid_reg;
    assign reply_kind = kind_reg;
    assign reply_data = data_reg;
    assign last_byte  = last_reg;
    assign irq_level  = oirq_reg;

    assign can_load = !out_valid_reg || !out_stall;
    assign value    = empty_reg ? 16'd0 : rdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        irq_next       = irq_reg;
        empty_next     = empty_reg;
        hold_a_next    = hold_a_reg;
        hold_b_next    = hold_b_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        oirq_next      = oirq_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    pop = 1'b1;
                    case (q_entry.op)
                        OP_INS_OK:
                        begin
                            mem_we = 1'b1;
                            // full ring: oldest entry is overwritten
                            if (count_reg == CNT_FULL)
                                rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                            else
                                count_next = count_reg + 1'b1;
                            wp_next        = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                            irq_next       = 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = KIND_STATUS;
                            data_next      = STATUS_OK;
                            last_next      = 1'b1;
                            oirq_next      = 1'b1;
                        end
                        OP_INS_REJ:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_STATUS;
                            data_next      = STATUS_REJ;
                            last_next      = 1'b1;
                            oirq_next      = irq_reg;
                        end
                        OP_READ:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_BYTE;
                            data_next      = q_entry.data[7:0];
                            last_next      = 1'b0;
                            oirq_next      = irq_reg;
                            hold_a_next    = q_entry.data[7:0];
                            left_next      = 2'd1;
                            state_next     = B_EMIT;
                        end
                        OP_FETCH:
                        begin
                            // ring read is issued this cycle, data arrives in B_RD
                            empty_next = (count_reg == '0);
                            if (count_reg != '0)
                            begin
                                rp_next    = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                if (count_reg == CNT_ONE)
                                    irq_next = 1'b0;
                            end
                            state_next = B_RD;
                        end
                        default: ;
                    endcase
                end
            end
            B_RD:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BYTE;
                    data_next      = value[15:8];
                    last_next      = 1'b0;
                    oirq_next      = irq_reg;
                    hold_a_next    = value[7:0];
                    hold_b_next    = value[15:8] ^ value[7:0];
                    left_next      = 2'd2;
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BYTE;
                    data_next      = hold_a_reg;
                    last_next      = (left_reg == 2'd1);
                    oirq_next      = irq_reg;
                    hold_a_next    = hold_b_reg;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == 2'd1)
                        state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= q_entry.data;
        if (state_reg == B_IDLE)
            rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg  <= empty_next;
        hold_a_reg <= hold_a_next;
        hold_b_reg <= hold_b_next;
        left_reg   <= left_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        oirq_reg   <= oirq_next;
    end

endmodule

// ===== rtl/event_notify_ring_queue.sv =====
// event notification ring queue: top level
// depends on enrq_pkg, enrq_front, enrq_cmdq, enrq_back
//
// usage:
//   request channel (in_valid/in_stall) carries command, event_class, event_id,
//   power_state and ready_value; a request is taken when in_valid is high and
//   in_stall is low. reply channel (out_valid/out_stall) returns reply_kind,
//   reply_data, last_byte and irq_level; a byte is taken when out_stall is low.
//   config port (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the power state
//   window; cfg_ready is always high. write it only while the block is idle.
// command flow:
//   the front classifies a request in the cycle it is taken and queues it in a
//   two-entry command queue. the back end runs one command at a time: insert
//   returns one status byte, read flag two bytes, fetch a ring read and three reply
//   bytes, all through the single output register. set ready flag gives no reply
//   and takes effect at once; a request waits in the command queue before its reply.
// reset: ring empty, pointers zero, ready flag and irq_reg low, window 3000..5000.
// stall: a stalled reply holds; the back end waits, the command queue fills
//   and in_stall rises once both queue entries are taken.
module event_notify_ring_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [7:0]                     event_class,
    input  logic [7:0]                     event_id,
    input  logic [15:0]                    power_state,
    input  logic [7:0]                     ready_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           reply_kind,
    output logic [7:0]                     reply_data,
    output logic                           last_byte,
    output logic                           irq_level,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [enrq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import enrq_pkg::*;

    logic       q_full;
    logic       push;
    cmd_entry_t push_entry;
    logic       q_valid;
    cmd_entry_t q_entry;
    logic       pop;

    enrq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .event_class (event_class),
        .event_id    (event_id),
        .power_state (power_state),
        .ready_value (ready_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    enrq_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    enrq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reply_kind (reply_kind),
        .reply_data (reply_data),
        .last_byte  (last_byte),
        .irq_level  (irq_level)
    );

endmodule
